// ===== rtl/ppt_pkg.sv =====
// Shared constants, codes and types for the positional pair table.
package ppt_pkg;

   localparam int CAPACITY    = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   // Fixed port field widths
   localparam int FIELD_W = 32;
   localparam int FUNC_W  = 2;
   localparam int POS_W   = 5;
   localparam int FOUND_W = 4;
   localparam int COUNT_W = 5;

   // Internal widths derived from capacity
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_UPDATE = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_MISS  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_FROM_LO,
      CELL_FROM_HI,
      CELL_LOAD,
      CELL_SET_VAL
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

endpackage

// ===== rtl/ppt_if.sv =====
// Request and response channel interfaces for the positional pair table.
interface ppt_req_if;
   logic                                  valid;
   logic                                  ready;
   ppt_pkg::func_type                     func;
   logic        [ppt_pkg::POS_W-1:0]      position;
   logic signed [ppt_pkg::FIELD_W-1:0]    key;
   logic signed [ppt_pkg::FIELD_W-1:0]    value;

   modport source (output valid, func, position, key, value, input ready);
   modport sink   (input valid, func, position, key, value, output ready);
endinterface

interface ppt_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ppt_pkg::FIELD_W-1:0]    key_out;
   logic signed [ppt_pkg::FIELD_W-1:0]    value_out;
   logic        [ppt_pkg::FOUND_W-1:0]    found_position;
   logic        [ppt_pkg::COUNT_W-1:0]    entry_count;
   ppt_pkg::status_type                   status;

   modport source (output valid, key_out, value_out, found_position, entry_count, status,
                   input ready);
   modport sink   (input valid, key_out, value_out, found_position, entry_count, status,
                   output ready);
endinterface

// ===== rtl/ppt_cell.sv =====
// One storage cell of the pair chain: holds a pair, takes a neighbor's pair, loads a new pair or sets its value.
module ppt_cell (
   input  logic                               clock,
   input  ppt_pkg::cell_ctl_type              ctl,
   input  logic [ppt_pkg::KEY_WIDTH-1:0]      lo_key,
   input  logic [ppt_pkg::VALUE_WIDTH-1:0]    lo_val,
   input  logic [ppt_pkg::KEY_WIDTH-1:0]      hi_key,
   input  logic [ppt_pkg::VALUE_WIDTH-1:0]    hi_val,
   input  logic [ppt_pkg::KEY_WIDTH-1:0]      new_key,
   input  logic [ppt_pkg::VALUE_WIDTH-1:0]    new_val,
   output logic [ppt_pkg::KEY_WIDTH-1:0]      key,
   output logic [ppt_pkg::VALUE_WIDTH-1:0]    val,
   output logic                               match
);

   logic [ppt_pkg::KEY_WIDTH-1:0]   key_ff, key_in;
   logic [ppt_pkg::VALUE_WIDTH-1:0] val_ff, val_in;

   always_comb begin
      key_in = key_ff;
      val_in = val_ff;
      unique case (ctl.op)
         ppt_pkg::CELL_HOLD: begin
         end
         ppt_pkg::CELL_FROM_LO: begin
            key_in = lo_key;
            val_in = lo_val;
         end
         ppt_pkg::CELL_FROM_HI: begin
            key_in = hi_key;
            val_in = hi_val;
         end
         ppt_pkg::CELL_LOAD: begin
            key_in = new_key;
            val_in = new_val;
         end
         ppt_pkg::CELL_SET_VAL: begin
            val_in = new_val;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
   end

   assign key   = key_ff;
   assign val   = val_ff;
   assign match = (key_ff == new_key);

endmodule

// ===== rtl/positional_pair_table.sv =====
// Top level of the positional pair table: control, cell chain and response register.
// Response valid is registered in the cycle after the request transaction.
// Throughput: one request per cycle unless stalled; the cell chain completes each operation.
// A new request is taken while the response register is empty or being drained.
// Reset (synchronous) clears the entry count and response valid; cell contents stay undefined.
module positional_pair_table (
   input  logic        clock,
   input  logic        reset,
   ppt_req_if.sink     req,
   ppt_rsp_if.source   rsp
);

   localparam int CAP = ppt_pkg::CAPACITY;
   localparam int KW  = ppt_pkg::KEY_WIDTH;
   localparam int VW  = ppt_pkg::VALUE_WIDTH;
   localparam int IW  = ppt_pkg::IDX_W;
   localparam int NW  = ppt_pkg::CNT_W;
   localparam int CW  = ppt_pkg::CMP_W;
   localparam int FW  = ppt_pkg::FIELD_W;

   logic [NW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]           key_out_ff, key_out_in;
   logic [FW-1:0]           value_out_ff, value_out_in;
   logic [ppt_pkg::FOUND_W-1:0] found_ff, found_in;
   ppt_pkg::status_type     status_ff, status_in;

   logic                    fire;
   logic [CW-1:0]           pos_ext, cnt_ext;
   logic [KW-1:0]           new_key;
   logic [VW-1:0]           new_val;

   ppt_pkg::cell_ctl_type   cell_ctl [CAP];
   logic [KW-1:0]           cell_key [CAP];
   logic [VW-1:0]           cell_val [CAP];
   logic [CAP-1:0]          cell_match;
   logic [CAP-1:0]          valid_mask;
   logic [CAP-1:0]          hit;
   logic [CAP-1:0]          first_hit;
   logic [IW-1:0]           found_idx;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;
   assign pos_ext   = CW'(req.position);
   assign cnt_ext   = CW'(count_ff);
   assign new_key   = KW'($unsigned(req.key));
   assign new_val   = VW'($unsigned(req.value));

   // Cell chain
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [KW-1:0] lo_key, hi_key;
      logic [VW-1:0] lo_val, hi_val;
      if (i == 0) begin : g_first
         assign lo_key = new_key;
         assign lo_val = new_val;
      end else begin : g_mid_lo
         assign lo_key = cell_key[i-1];
         assign lo_val = cell_val[i-1];
      end
      if (i == CAP - 1) begin : g_last
         assign hi_key = cell_key[i];
         assign hi_val = cell_val[i];
      end else begin : g_mid_hi
         assign hi_key = cell_key[i+1];
         assign hi_val = cell_val[i+1];
      end
      ppt_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[i]),
         .lo_key  (lo_key),
         .lo_val  (lo_val),
         .hi_key  (hi_key),
         .hi_val  (hi_val),
         .new_key (new_key),
         .new_val (new_val),
         .key     (cell_key[i]),
         .val     (cell_val[i]),
         .match   (cell_match[i])
      );
   end

   // First matching live entry
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         valid_mask[i] = (NW'(i) < count_ff);
      end
      hit       = cell_match & valid_mask;
      first_hit = hit & (~hit + CAP'(1));
      found_idx = '0;
      for (int i = 0; i < CAP; i++) begin
         if (first_hit[i]) begin
            found_idx = found_idx | IW'(i);
         end
      end
   end

   // Request decode, per-cell control and result
   always_comb begin
      count_in     = count_ff;
      status_in    = ppt_pkg::STATUS_OK;
      key_out_in   = '0;
      value_out_in = '0;
      found_in     = '0;
      for (int i = 0; i < CAP; i++) begin
         cell_ctl[i].op = ppt_pkg::CELL_HOLD;
      end
      unique case (req.func)
         ppt_pkg::FUNC_INSERT: begin
            if (count_ff == NW'(CAP)) begin
               status_in = ppt_pkg::STATUS_FULL;
            end else if (pos_ext > cnt_ext) begin
               status_in = ppt_pkg::STATUS_RANGE;
            end else begin
               count_in = count_ff + NW'(1);
               for (int i = 0; i < CAP; i++) begin
                  if (CW'(i) > pos_ext) begin
                     cell_ctl[i].op = ppt_pkg::CELL_FROM_LO;
                  end else if (CW'(i) == pos_ext) begin
                     cell_ctl[i].op = ppt_pkg::CELL_LOAD;
                  end
               end
            end
         end
         ppt_pkg::FUNC_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ppt_pkg::STATUS_RANGE;
            end else begin
               count_in = count_ff - NW'(1);
               for (int i = 0; i < CAP; i++) begin
                  if (CW'(i) >= pos_ext) begin
                     cell_ctl[i].op = ppt_pkg::CELL_FROM_HI;
                  end
               end
            end
         end
         ppt_pkg::FUNC_UPDATE: begin
            if (hit == '0) begin
               status_in = ppt_pkg::STATUS_MISS;
            end else begin
               value_out_in = FW'(new_val);
               found_in     = ppt_pkg::FOUND_W'(found_idx);
               for (int i = 0; i < CAP; i++) begin
                  if (first_hit[i]) begin
                     cell_ctl[i].op = ppt_pkg::CELL_SET_VAL;
                  end
               end
            end
         end
         ppt_pkg::FUNC_READ: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ppt_pkg::STATUS_RANGE;
            end else begin
               key_out_in   = FW'(cell_key[pos_ext[IW-1:0]]);
               value_out_in = FW'(cell_val[pos_ext[IW-1:0]]);
            end
         end
         default: begin
         end
      endcase
      // Cells only move on an accepted transaction
      if (!fire) begin
         count_in = count_ff;
         for (int i = 0; i < CAP; i++) begin
            cell_ctl[i].op = ppt_pkg::CELL_HOLD;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         key_out_ff   <= key_out_in;
         value_out_ff <= value_out_in;
         found_ff     <= found_in;
         status_ff    <= status_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.key_out        = key_out_ff;
   assign rsp.value_out      = value_out_ff;
   assign rsp.found_position = found_ff;
   assign rsp.entry_count    = ppt_pkg::COUNT_W'(count_ff);
   assign rsp.status         = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(CAP))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      fire && req.func == ppt_pkg::FUNC_INSERT && status_in == ppt_pkg::STATUS_OK
      |=> count_ff == $past(count_ff) + NW'(1))
      else $error("insert did not grow entry count");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_hit))
      else $error("update selected more than one cell");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ppt_pkg::STATUS_FULL |-> count_ff == NW'(CAP))
      else $error("full status reported while table not full");

   a_hold_unfired: assert property (@(posedge clock) disable iff (reset)
      !fire |=> count_ff == $past(count_ff))
      else $error("entry count changed without a transaction");

endmodule

// ===== dv/tb.sv =====
// Testbench for positional_pair_table: directed plan plus random traffic, checked by a predictor or fixed responses.
`timescale 1ns / 100ps

module tb;

   typedef struct packed {
      ppt_pkg::func_type                  func;
      logic [ppt_pkg::POS_W-1:0]          position;
      logic [ppt_pkg::FIELD_W-1:0]        key;
      logic [ppt_pkg::FIELD_W-1:0]        value;
   } request_type;

   typedef struct packed {
      logic [ppt_pkg::FIELD_W-1:0]        key_out;
      logic [ppt_pkg::FIELD_W-1:0]        value_out;
      logic [ppt_pkg::FOUND_W-1:0]        found_position;
      logic [ppt_pkg::COUNT_W-1:0]        entry_count;
      ppt_pkg::status_type                status;
   } response_type;

   // One row of the directed plan; reps > 1 repeats the request with value + index.
   typedef struct packed {
      ppt_pkg::func_type                  func;
      logic [ppt_pkg::POS_W-1:0]          position;
      logic [ppt_pkg::FIELD_W-1:0]        key;
      logic [ppt_pkg::FIELD_W-1:0]        value;
      logic [4:0]                         reps;
      logic                               fixed_rsp;
      ppt_pkg::status_type                status;
      logic [ppt_pkg::FIELD_W-1:0]        key_out;
      logic [ppt_pkg::FIELD_W-1:0]        value_out;
      logic [ppt_pkg::COUNT_W-1:0]        count;
   } plan_row_type;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_CHURN} traffic_mode_type;

   localparam int RANDOM_ITEMS = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppt_req_if req_ch ();
   ppt_rsp_if rsp_ch ();

   positional_pair_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // Shadow copy of the table
   logic [ppt_pkg::FIELD_W-1:0] table_keys [ppt_pkg::CAPACITY];
   logic [ppt_pkg::FIELD_W-1:0] table_vals [ppt_pkg::CAPACITY];
   int                          table_count = 0;

   response_type pending_rsp [$];
   int           mismatches = 0;
   int           responses_seen = 0;
   bit           sender_calm = 1'b0;

   logic [ppt_pkg::FIELD_W-1:0] key_pool [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
      32'h7fff_ffff, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678};

   plan_row_type directed_plan [20] = '{
      '{ppt_pkg::FUNC_READ,    0, 32'h0,         32'h0,         1, 1,
        ppt_pkg::STATUS_RANGE, 0, 0,  0},
      '{ppt_pkg::FUNC_REMOVE,  0, 32'h0,         32'h0,         1, 1,
        ppt_pkg::STATUS_RANGE, 0, 0,  0},
      '{ppt_pkg::FUNC_UPDATE,  0, 32'h5,         32'h7,         1, 1,
        ppt_pkg::STATUS_MISS,  0, 0,  0},
      '{ppt_pkg::FUNC_INSERT,  1, 32'h1,         32'h1,         1, 1,
        ppt_pkg::STATUS_RANGE, 0, 0,  0},
      '{ppt_pkg::FUNC_INSERT,  0, 32'h8000_0000, 32'h7fff_ffff, 1, 1,
        ppt_pkg::STATUS_OK,    0, 0,  1},
      '{ppt_pkg::FUNC_INSERT,  1, 32'h7fff_ffff, 32'h8000_0000, 1, 1,
        ppt_pkg::STATUS_OK,    0, 0,  2},
      '{ppt_pkg::FUNC_INSERT,  0, 32'h0,         32'hffff_ffff, 1, 1,
        ppt_pkg::STATUS_OK,    0, 0,  3},
      '{ppt_pkg::FUNC_READ,    0, 32'h0,         32'h0,         1, 1,
        ppt_pkg::STATUS_OK,    0, 32'hffff_ffff, 3},
      '{ppt_pkg::FUNC_READ,    2, 32'h0,         32'h0,         1, 0,
        ppt_pkg::STATUS_OK,    0, 0,  0},
      '{ppt_pkg::FUNC_UPDATE, 31, 32'h7fff_ffff, 32'h1234_5678, 1, 0,
        ppt_pkg::STATUS_OK,    0, 0,  0},
      '{ppt_pkg::FUNC_INSERT, 31, 32'hffff_ffff, 32'h0,         1, 1,
        ppt_pkg::STATUS_RANGE, 0, 0,  3},
      '{ppt_pkg::FUNC_REMOVE, 31, 32'h0,         32'h0,         1, 1,
        ppt_pkg::STATUS_RANGE, 0, 0,  3},
      '{ppt_pkg::FUNC_READ,    3, 32'h0,         32'h0,         1, 1,
        ppt_pkg::STATUS_RANGE, 0, 0,  3},
      '{ppt_pkg::FUNC_REMOVE,  1, 32'h0,         32'h0,         1, 0,
        ppt_pkg::STATUS_OK,    0, 0,  0},
      // fill up with duplicate keys so the update below must take the first match
      '{ppt_pkg::FUNC_INSERT,  2, 32'ha5a5_a5a5, 32'h5a5a_5a50, 14, 0,
        ppt_pkg::STATUS_OK,    0, 0,  0},
      '{ppt_pkg::FUNC_INSERT, 16, 32'h1,         32'h2,         1, 1,
        ppt_pkg::STATUS_FULL,  0, 0, 16},
      '{ppt_pkg::FUNC_UPDATE,  0, 32'ha5a5_a5a5, 32'h0,         1, 0,
        ppt_pkg::STATUS_OK,    0, 0,  0},
      '{ppt_pkg::FUNC_READ,   16, 32'h0,         32'h0,         1, 1,
        ppt_pkg::STATUS_RANGE, 0, 0, 16},
      '{ppt_pkg::FUNC_REMOVE, 15, 32'h0,         32'h0,         1, 0,
        ppt_pkg::STATUS_OK,    0, 0,  0},
      '{ppt_pkg::FUNC_UPDATE,  0, 32'hdead_beef, 32'h1,         1, 1,
        ppt_pkg::STATUS_MISS,  0, 0, 15}
   };

   function automatic response_type apply_request(request_type rq);
      response_type r;
      int           i;
      r = '0;
      r.status = ppt_pkg::STATUS_OK;
      case (rq.func)
         ppt_pkg::FUNC_INSERT: begin
            if (table_count >= ppt_pkg::CAPACITY) begin
               r.status = ppt_pkg::STATUS_FULL;
            end else if (rq.position > table_count) begin
               r.status = ppt_pkg::STATUS_RANGE;
            end else begin
               for (i = table_count; i > rq.position; i--) begin
                  table_keys[i] = table_keys[i-1];
                  table_vals[i] = table_vals[i-1];
               end
               table_keys[rq.position[ppt_pkg::IDX_W-1:0]] = rq.key;
               table_vals[rq.position[ppt_pkg::IDX_W-1:0]] = rq.value;
               table_count++;
            end
         end
         ppt_pkg::FUNC_REMOVE: begin
            if (rq.position >= table_count) begin
               r.status = ppt_pkg::STATUS_RANGE;
            end else begin
               for (i = rq.position; i + 1 < table_count; i++) begin
                  table_keys[i] = table_keys[i+1];
                  table_vals[i] = table_vals[i+1];
               end
               table_count--;
            end
         end
         ppt_pkg::FUNC_UPDATE: begin
            r.status = ppt_pkg::STATUS_MISS;
            for (i = 0; i < table_count; i++) begin
               if (r.status == ppt_pkg::STATUS_MISS && table_keys[i] == rq.key) begin
                  table_vals[i] = rq.value;
                  r.value_out = rq.value;
                  r.found_position = i[ppt_pkg::FOUND_W-1:0];
                  r.status = ppt_pkg::STATUS_OK;
               end
            end
         end
         default: begin
            if (rq.position >= table_count) begin
               r.status = ppt_pkg::STATUS_RANGE;
            end else begin
               r.key_out = table_keys[rq.position[ppt_pkg::IDX_W-1:0]];
               r.value_out = table_vals[rq.position[ppt_pkg::IDX_W-1:0]];
            end
         end
      endcase
      r.entry_count = table_count[ppt_pkg::COUNT_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic request_type random_request(traffic_mode_type mode);
      request_type rq;
      int          r;
      int          ins_lim;
      int          rem_lim;
      int          upd_lim;
      case (mode)
         MODE_GROW:   begin ins_lim = 55; rem_lim = 70; upd_lim = 85; end
         MODE_SHRINK: begin ins_lim = 15; rem_lim = 65; upd_lim = 80; end
         default:     begin ins_lim = 25; rem_lim = 50; upd_lim = 75; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_lim)      rq.func = ppt_pkg::FUNC_INSERT;
      else if (r < rem_lim) rq.func = ppt_pkg::FUNC_REMOVE;
      else if (r < upd_lim) rq.func = ppt_pkg::FUNC_UPDATE;
      else                  rq.func = ppt_pkg::FUNC_READ;

      if ($urandom_range(0, 99) < 12)
         rq.position = ppt_pkg::POS_W'($urandom_range(0, 31));
      else if (rq.func == ppt_pkg::FUNC_INSERT)
         rq.position = ppt_pkg::POS_W'($urandom_range(0, table_count));
      else
         rq.position = (table_count > 0) ?
                       ppt_pkg::POS_W'($urandom_range(0, table_count - 1)) : '0;

      // pooled keys make updates hit and create duplicates
      if ($urandom_range(0, 99) < ((rq.func == ppt_pkg::FUNC_UPDATE) ? 85 : 60))
         rq.key = key_pool[$urandom_range(0, 7)];
      else
         rq.key = $urandom;
      rq.value = $urandom;
      return rq;
   endfunction

   task automatic offer(input request_type rq, input bit use_fixed, input response_type fixed);
      int           gap;
      response_type predicted;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= rq.func;
      req_ch.position <= rq.position;
      req_ch.key      <= rq.key;
      req_ch.value    <= rq.value;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predicted = apply_request(rq);
      if (use_fixed) predicted = fixed;
      pending_rsp = {pending_rsp, predicted};
   endtask

   // Stimulus
   initial begin
      request_type      rq;
      response_type     want;
      traffic_mode_type mode;
      int               k;
      int               sent;
      int               phase_len;
      req_ch.valid    = 1'b0;
      req_ch.func     = ppt_pkg::FUNC_INSERT;
      req_ch.position = '0;
      req_ch.key      = '0;
      req_ch.value    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[n]) begin
         for (k = 0; k < directed_plan[n].reps; k++) begin
            rq.func     = directed_plan[n].func;
            rq.position = directed_plan[n].position;
            rq.key      = directed_plan[n].key;
            rq.value    = directed_plan[n].value + k;
            want.key_out        = directed_plan[n].key_out;
            want.value_out      = directed_plan[n].value_out;
            want.found_position = '0;
            want.entry_count    = directed_plan[n].count;
            want.status         = directed_plan[n].status;
            offer(rq, directed_plan[n].fixed_rsp, want);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = traffic_mode_type'($urandom_range(0, 2));
         phase_len = $urandom_range(30, 80);
         if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
         sender_calm = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            offer(random_request(mode), 1'b0, '0);
            sent++;
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Response side backpressure
   initial begin
      int stall_left;
      int calm_left;
      int hold_left;
      int next_hold;
      int r;
      bit go;
      stall_left = 0;
      calm_left  = 0;
      hold_left  = 0;
      next_hold  = 150;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            go = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            go = 1'b0;
         end else if (responses_seen >= next_hold) begin
            // long hold-off so the response register fills and the request side stalls
            hold_left = 59;
            next_hold += 400;
            go = 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            go = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            go = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               calm_left = $urandom_range(20, 80);
               go = 1'b1;
            end else if (r < 25) begin
               stall_left = $urandom_range(0, 2);
               go = 1'b0;
            end else if (r < 28) begin
               stall_left = $urandom_range(5, 25);
               go = 1'b0;
            end else begin
               go = 1'b1;
            end
         end
         rsp_ch.ready <= go;
      end
   end

   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         responses_seen++;
         if (pending_rsp.size() == 0) begin
            $error("response transaction with nothing pending");
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.key_out !== want.key_out) begin
               $error("key_out expected %h actual %h", want.key_out, rsp_ch.key_out);
               mismatches++;
            end
            if (rsp_ch.value_out !== want.value_out) begin
               $error("value_out expected %h actual %h", want.value_out, rsp_ch.value_out);
               mismatches++;
            end
            if (rsp_ch.found_position !== want.found_position) begin
               $error("found_position expected %0d actual %0d",
                      want.found_position, rsp_ch.found_position);
               mismatches++;
            end
            if (rsp_ch.entry_count !== want.entry_count) begin
               $error("entry_count expected %0d actual %0d",
                      want.entry_count, rsp_ch.entry_count);
               mismatches++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_ch.status);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
